[rtl/core/lewh_pkg.sv]
// Shared types, constants and helpers of the line editor with history.
`timescale 1ns / 1ps
package lewh_pkg;

    localparam int LINE_BYTES_DEF    = 128;
    localparam int HISTORY_DEPTH_DEF = 10;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    typedef enum logic [1:0] {
        MODE_KEY   = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_ENTER = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    localparam logic [7:0] KEY_BACKSPACE = 8'd127;
    localparam logic [7:0] KEY_DELETE    = 8'h33;
    localparam logic [7:0] KEY_LEFT      = 8'h44;
    localparam logic [7:0] KEY_RIGHT     = 8'h43;
    localparam logic [7:0] KEY_UP        = 8'h41;
    localparam logic [7:0] KEY_DOWN      = 8'h42;
    localparam logic [7:0] KEY_COLON     = 8'h3a;
    localparam logic [7:0] KEY_SLASH     = 8'h2f;
    localparam logic [7:0] KEY_SPACE     = 8'h20;

    function automatic logic is_insertable(input logic [7:0] k);
        logic lower;
        logic upper;
        logic digit;
        lower = (k >= 8'h61) && (k <= 8'h7a);
        upper = (k >= 8'h41) && (k <= 8'h5a);
        digit = (k >= 8'h30) && (k <= 8'h39);
        return lower || upper || digit || (k == KEY_SPACE) || (k == KEY_COLON) ||
               (k == KEY_SLASH);
    endfunction

endpackage

[rtl/core/lewh_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module lewh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/line_editor_with_history.sv]
// Top level of the console line editor with command history.
//
// Usage: one key event per s_ transfer, one result per m_ transfer.
// The event enters when s_tvalid and s_tready are high; s_tready is high only
// while the sequencer is idle. The event is then worked through byte by byte
// by one sequencer over the line RAM and the history RAM, since the line RAM
// has a single read port. Cursor moves and ignored keys write no RAM; insert,
// backspace and delete move the bytes after the cursor; history recall
// copies the recalled entry into the line; enter compares the line with the
// newest history entry and stores it as a new entry when they differ. The
// result waits in an output register; a stalled m_ side holds the sequencer
// in its last state, and a new event may already be taken while a result
// waits. Reset empties the line and the history and needs no clearing pass;
// RAM contents are only read once written.
`timescale 1ns / 1ps
module line_editor_with_history #(
    parameter int LINE_BYTES    = lewh_pkg::LINE_BYTES_DEF,
    parameter int HISTORY_DEPTH = lewh_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // mode[1:0], key[9:2], read_index[16:10], zero pad
    input  logic [lewh_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // line_length[6:0], cursor_pos[13:7], read_char[21:14],
    // history_count[25:22], line_changed[26], committed[27], zero pad
    output logic [lewh_pkg::M_DATA_W-1:0] m_tdata
);
    import lewh_pkg::*;

    localparam int LW     = $clog2(LINE_BYTES);
    localparam int AW     = $clog2(HISTORY_DEPTH + 1);
    localparam int SW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HDEPTH = HISTORY_DEPTH * LINE_BYTES;
    localparam int HAW    = $clog2(HDEPTH);

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_INS_RD = 16'h0002,
        S_INS_WR = 16'h0004,
        S_DL_RD  = 16'h0008,
        S_DL_WR  = 16'h0010,
        S_RC_SET = 16'h0020,
        S_RC_RD  = 16'h0040,
        S_RC_WR  = 16'h0080,
        S_CM_CHK = 16'h0100,
        S_CM_RD  = 16'h0200,
        S_CM_CMP = 16'h0400,
        S_CP_SET = 16'h0800,
        S_CP_RD  = 16'h1000,
        S_CP_WR  = 16'h2000,
        S_FIN    = 16'h4000,
        S_OUT    = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    logic [LW-1:0]  len_reg, len_next;
    logic [LW-1:0]  cur_reg, cur_next;
    logic [LW-1:0]  idx_reg, idx_next;
    logic [LW-1:0]  n_reg, n_next;
    logic [AW-1:0]  used_reg, used_next;
    logic [SW-1:0]  newest_reg, newest_next;
    logic [SW-1:0]  hslot_reg, hslot_next;
    logic           browsing_reg, browsing_next;
    logic [AW-1:0]  bpos_reg, bpos_next;
    logic [7:0]     key_reg, key_next;
    logic           bs_reg, bs_next;
    logic [6:0]     ridx_reg, ridx_next;
    logic           changed_reg, changed_next;
    logic           stored_reg, stored_next;
    logic           m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic [LW-1:0]  hlen_reg [HISTORY_DEPTH];
    logic           hlen_we;

    logic           lram_we;
    logic [LW-1:0]  lram_waddr, lram_raddr;
    logic [7:0]     lram_wdata, lram_rdata;
    logic           hram_we;
    logic [HAW-1:0] hram_addr;
    logic [7:0]     hram_rdata;

    logic [1:0]     in_mode;
    logic [7:0]     in_key;
    logic [6:0]     in_ridx;
    logic [AW-1:0]  age_up, age_down, age_sel;
    logic [AW:0]    slot_wide;
    logic [SW-1:0]  slot_of_age, slot_new;
    logic [LW-1:0]  hlen_cur;
    logic [8:0]     ridx9, len9, cur9;
    logic [7:0]     used8;
    logic [7:0]     read_char;

    assign in_mode = s_tdata[1:0];
    assign in_key  = s_tdata[9:2];
    assign in_ridx = s_tdata[16:10];

    assign age_up   = browsing_reg ? AW'(bpos_reg + AW'(1)) : '0;
    assign age_down = AW'(bpos_reg - AW'(1));
    assign age_sel  = (in_key == KEY_UP) ? age_up : age_down;

    always_comb begin
        if ((AW + 1)'(newest_reg) >= (AW + 1)'(age_sel)) begin
            slot_wide = (AW + 1)'(newest_reg) - (AW + 1)'(age_sel);
        end else begin
            slot_wide = (AW + 1)'(newest_reg) + (AW + 1)'(HISTORY_DEPTH) -
                        (AW + 1)'(age_sel);
        end
    end
    assign slot_of_age = slot_wide[SW-1:0];
    assign slot_new    = ((AW + 1)'(newest_reg) + (AW + 1)'(1) ==
                          (AW + 1)'(HISTORY_DEPTH)) ? '0 : SW'(newest_reg + SW'(1));

    assign hlen_cur  = hlen_reg[hslot_reg];
    assign hram_addr = HAW'(hslot_reg * LINE_BYTES) + HAW'(idx_reg);

    assign ridx9     = 9'(ridx_reg);
    assign len9      = 9'(len_reg);
    assign cur9      = 9'(cur_reg);
    assign used8     = 8'(used_reg);
    assign read_char = (ridx9 < len9) ? lram_rdata : 8'd0;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        cur_next      = cur_reg;
        idx_next      = idx_reg;
        n_next        = n_reg;
        used_next     = used_reg;
        newest_next   = newest_reg;
        hslot_next    = hslot_reg;
        browsing_next = browsing_reg;
        bpos_next     = bpos_reg;
        key_next      = key_reg;
        bs_next       = bs_reg;
        ridx_next     = ridx_reg;
        changed_next  = changed_reg;
        stored_next   = stored_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        hlen_we       = 1'b0;
        lram_we       = 1'b0;
        lram_waddr    = idx_reg;
        lram_wdata    = lram_rdata;
        lram_raddr    = idx_reg;
        hram_we       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    key_next     = in_key;
                    ridx_next    = in_ridx;
                    changed_next = 1'b0;
                    stored_next  = 1'b0;
                    state_next   = S_FIN;
                    case (in_mode)
                        MODE_KEY: begin
                            if (is_insertable(in_key) &&
                                (9'(len_reg) + 9'd1 < 9'(LINE_BYTES))) begin
                                idx_next   = len_reg;
                                state_next = S_INS_RD;
                            end else if (in_key == KEY_BACKSPACE && cur_reg != '0) begin
                                idx_next   = LW'(cur_reg - LW'(1));
                                bs_next    = 1'b1;
                                state_next = S_DL_RD;
                            end
                        end
                        MODE_ESC: begin
                            if (in_key == KEY_LEFT) begin
                                if (cur_reg != '0) begin
                                    cur_next     = LW'(cur_reg - LW'(1));
                                    changed_next = 1'b1;
                                end
                            end else if (in_key == KEY_RIGHT) begin
                                if (cur_reg < len_reg) begin
                                    cur_next     = LW'(cur_reg + LW'(1));
                                    changed_next = 1'b1;
                                end
                            end else if (in_key == KEY_UP) begin
                                if (age_up < used_reg) begin
                                    bpos_next     = age_up;
                                    browsing_next = 1'b1;
                                    hslot_next    = slot_of_age;
                                    state_next    = S_RC_SET;
                                end
                            end else if (in_key == KEY_DOWN) begin
                                if (browsing_reg && bpos_reg != '0) begin
                                    bpos_next  = age_down;
                                    hslot_next = slot_of_age;
                                    state_next = S_RC_SET;
                                end
                            end else if (in_key == KEY_DELETE) begin
                                if (cur_reg < len_reg) begin
                                    idx_next   = cur_reg;
                                    bs_next    = 1'b0;
                                    state_next = S_DL_RD;
                                end
                            end
                        end
                        MODE_ENTER: begin
                            browsing_next = 1'b0;
                            changed_next  = (len_reg != '0) || (cur_reg != '0);
                            if (used_reg == '0) begin
                                if (len_reg == '0) begin
                                    state_next = S_FIN;
                                end else begin
                                    state_next = S_CP_SET;
                                end
                            end else begin
                                hslot_next = newest_reg;
                                state_next = S_CM_CHK;
                            end
                        end
                        default: begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (idx_reg == cur_reg) begin
                    lram_we      = 1'b1;
                    lram_waddr   = cur_reg;
                    lram_wdata   = key_reg;
                    len_next     = LW'(len_reg + LW'(1));
                    cur_next     = LW'(cur_reg + LW'(1));
                    changed_next = 1'b1;
                    state_next   = S_FIN;
                end else begin
                    lram_raddr = LW'(idx_reg - LW'(1));
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR: begin
                lram_we    = 1'b1;
                idx_next   = LW'(idx_reg - LW'(1));
                state_next = S_INS_RD;
            end
            S_DL_RD: begin
                if (LW'(idx_reg + LW'(1)) == len_reg) begin
                    len_next     = LW'(len_reg - LW'(1));
                    if (bs_reg) begin
                        cur_next = LW'(cur_reg - LW'(1));
                    end
                    changed_next = 1'b1;
                    state_next   = S_FIN;
                end else begin
                    lram_raddr = LW'(idx_reg + LW'(1));
                    state_next = S_DL_WR;
                end
            end
            S_DL_WR: begin
                lram_we    = 1'b1;
                idx_next   = LW'(idx_reg + LW'(1));
                state_next = S_DL_RD;
            end
            S_RC_SET: begin
                n_next       = hlen_cur;
                changed_next = (hlen_cur != len_reg) || (hlen_cur != cur_reg);
                idx_next     = '0;
                state_next   = S_RC_RD;
            end
            S_RC_RD: begin
                if (idx_reg == n_reg) begin
                    len_next   = n_reg;
                    cur_next   = n_reg;
                    state_next = S_FIN;
                end else begin
                    state_next = S_RC_WR;
                end
            end
            S_RC_WR: begin
                lram_we    = 1'b1;
                lram_wdata = hram_rdata;
                if (hram_rdata != lram_rdata) begin
                    changed_next = 1'b1;
                end
                idx_next   = LW'(idx_reg + LW'(1));
                state_next = S_RC_RD;
            end
            S_CM_CHK: begin
                if (hlen_cur != len_reg) begin
                    state_next = S_CP_SET;
                end else begin
                    idx_next   = '0;
                    state_next = S_CM_RD;
                end
            end
            S_CM_RD: begin
                if (idx_reg == len_reg) begin
                    len_next   = '0;
                    cur_next   = '0;
                    state_next = S_FIN;
                end else begin
                    state_next = S_CM_CMP;
                end
            end
            S_CM_CMP: begin
                if (hram_rdata != lram_rdata) begin
                    state_next = S_CP_SET;
                end else begin
                    idx_next   = LW'(idx_reg + LW'(1));
                    state_next = S_CM_RD;
                end
            end
            S_CP_SET: begin
                hslot_next = slot_new;
                idx_next   = '0;
                state_next = S_CP_RD;
            end
            S_CP_RD: begin
                if (idx_reg == len_reg) begin
                    hlen_we     = 1'b1;
                    newest_next = hslot_reg;
                    if (8'(used_reg) < 8'(HISTORY_DEPTH)) begin
                        used_next = AW'(used_reg + AW'(1));
                    end
                    stored_next = 1'b1;
                    len_next    = '0;
                    cur_next    = '0;
                    state_next  = S_FIN;
                end else begin
                    state_next = S_CP_WR;
                end
            end
            S_CP_WR: begin
                hram_we    = 1'b1;
                idx_next   = LW'(idx_reg + LW'(1));
                state_next = S_CP_RD;
            end
            S_FIN: begin
                lram_raddr = ridx9[LW-1:0];
                state_next = S_OUT;
            end
            S_OUT: begin
                lram_raddr = ridx9[LW-1:0];
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'd0, stored_reg, changed_reg, used8[3:0], read_char,
                                    cur9[6:0], len9[6:0]};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            len_reg      <= '0;
            cur_reg      <= '0;
            used_reg     <= '0;
            newest_reg   <= '0;
            browsing_reg <= 1'b0;
            bpos_reg     <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                hlen_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            cur_reg      <= cur_next;
            used_reg     <= used_next;
            newest_reg   <= newest_next;
            browsing_reg <= browsing_next;
            bpos_reg     <= bpos_next;
            m_valid_reg  <= m_valid_next;
            if (hlen_we) begin
                hlen_reg[hslot_reg] <= len_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        n_reg       <= n_next;
        hslot_reg   <= hslot_next;
        key_reg     <= key_next;
        bs_reg      <= bs_next;
        ridx_reg    <= ridx_next;
        changed_reg <= changed_next;
        stored_reg  <= stored_next;
        m_data_reg  <= m_data_next;
    end

    lewh_ram #(
        .WIDTH (8),
        .DEPTH (LINE_BYTES)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (lram_we),
        .waddr (lram_waddr),
        .wdata (lram_wdata),
        .raddr (lram_raddr),
        .rdata (lram_rdata)
    );

    lewh_ram #(
        .WIDTH (8),
        .DEPTH (HDEPTH)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (hram_we),
        .waddr (hram_addr),
        .wdata (lram_rdata),
        .raddr (hram_addr),
        .rdata (hram_rdata)
    );

endmodule

[rtl/core/lewh_checker.sv]
// Port-level checker for the line editor, bound to the top level.
`timescale 1ns / 1ps
module lewh_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [lewh_pkg::S_DATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lewh_pkg::M_DATA_W-1:0] m_tdata
);
    import lewh_pkg::*;

    // busy after every accepted transfer
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_commit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[27] |-> m_tdata[13:0] == 14'd0)
        else $error("commit left line not empty");

    a_cursor_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[13:7] <= m_tdata[6:0])
        else $error("cursor beyond line end");

endmodule

bind line_editor_with_history lewh_checker u_lewh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
